// ===== hw/rtl/ufc_pkg.sv =====
`timescale 1ns / 1ps

package ufc_pkg;

    // Table geometry. The field widths below are fixed by the item layout.
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int RANK_W    = 3;
    localparam int UPC_W     = 4;

    localparam logic [CNT_W-1:0]  VERTEX_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  NODE_LIMIT         = 7'd64;
    localparam logic [RANK_W-1:0] RANK_MAX           = 3'd7;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [UPC_W-1:0]  upc_t;

    // Operation codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_UNION  = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_COUNT  = 2'd2,
        MODE_REINIT = 2'd3
    } ufc_mode_t;

    // Input and result transactions.
    typedef struct packed {
        logic [1:0] mode;
        node_t      node_a;
        node_t      node_b;
    } ufc_in_t;

    typedef struct packed {
        node_t  root;
        count_t component_count;
        logic   status;
    } ufc_out_t;

    // Datapath actions selected by one control word.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_DISPATCH,
        UOP_RD_R,
        UOP_STEP_R,
        UOP_RD_CUR,
        UOP_COMPRESS,
        UOP_SAVE_ROOT,
        UOP_LOAD_B,
        UOP_RD_RANK1,
        UOP_RD_RANK2,
        UOP_LINK,
        UOP_CNT_RD,
        UOP_CNT_STEP,
        UOP_REINIT,
        UOP_EMIT
    } ufc_uop_t;

    // Jump conditions; a false condition falls through to the next step.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_DISPATCH,
        COND_PAR_NE_R,
        COND_CUR_EQ_R,
        COND_MODE_FIND,
        COND_PHASE_B,
        COND_ROOTS_EQ,
        COND_IDX_DONE,
        COND_OUT_BUSY
    } ufc_cond_t;

    typedef struct packed {
        ufc_uop_t  uop;
        ufc_cond_t cond;
        upc_t      target;
    } ufc_ctrl_t;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        ufc_mode_t mode;
        logic      err;
        logic      par_ne_r;
        logic      cur_eq_r;
        logic      phase_b;
        logic      roots_eq;
        logic      idx_done;
    } ufc_stat_t;

    // Access request to the parent and rank tables for the current step.
    typedef struct packed {
        logic  p_rd_en;
        node_t p_rd_addr;
        logic  p_wr_en;
        node_t p_wr_addr;
        node_t p_wr_data;
        logic  k_rd_en;
        node_t k_rd_addr;
        logic  k_wr_en;
        node_t k_wr_addr;
        rank_t k_wr_data;
        logic  clear;
    } ufc_tbl_req_t;

    // Program step addresses.
    localparam upc_t S_FIND_RD   = 4'd0;
    localparam upc_t S_FIND_CHK  = 4'd1;
    localparam upc_t S_CMP_RD    = 4'd2;
    localparam upc_t S_CMP_WR    = 4'd3;
    localparam upc_t S_FIND_END  = 4'd4;
    localparam upc_t S_NEXT      = 4'd5;
    localparam upc_t S_LOAD_B    = 4'd6;
    localparam upc_t S_UNI_RK1   = 4'd7;
    localparam upc_t S_UNI_RK2   = 4'd8;
    localparam upc_t S_UNI_LINK  = 4'd9;
    localparam upc_t S_CNT_RD    = 4'd10;
    localparam upc_t S_CNT_STEP  = 4'd11;
    localparam upc_t S_REINIT    = 4'd12;
    localparam upc_t S_EMIT      = 4'd13;
    localparam upc_t S_IDLE      = 4'd14;
    localparam upc_t S_DISPATCH  = 4'd15;

    // The microprogram. Each find walks to the root, then walks again to
    // point every node on the path at that root.
    function automatic ufc_ctrl_t ufc_rom(input upc_t pc);
        ufc_ctrl_t w;
        case (pc)
            S_FIND_RD:  w = '{UOP_RD_R,      COND_NEVER,     S_FIND_RD};
            S_FIND_CHK: w = '{UOP_STEP_R,    COND_PAR_NE_R,  S_FIND_RD};
            S_CMP_RD:   w = '{UOP_RD_CUR,    COND_CUR_EQ_R,  S_FIND_END};
            S_CMP_WR:   w = '{UOP_COMPRESS,  COND_ALWAYS,    S_CMP_RD};
            S_FIND_END: w = '{UOP_SAVE_ROOT, COND_MODE_FIND, S_EMIT};
            S_NEXT:     w = '{UOP_NOP,       COND_PHASE_B,   S_UNI_RK1};
            S_LOAD_B:   w = '{UOP_LOAD_B,    COND_ALWAYS,    S_FIND_RD};
            S_UNI_RK1:  w = '{UOP_RD_RANK1,  COND_ROOTS_EQ,  S_EMIT};
            S_UNI_RK2:  w = '{UOP_RD_RANK2,  COND_NEVER,     S_UNI_LINK};
            S_UNI_LINK: w = '{UOP_LINK,      COND_ALWAYS,    S_EMIT};
            S_CNT_RD:   w = '{UOP_CNT_RD,    COND_IDX_DONE,  S_EMIT};
            S_CNT_STEP: w = '{UOP_CNT_STEP,  COND_ALWAYS,    S_CNT_RD};
            S_REINIT:   w = '{UOP_REINIT,    COND_ALWAYS,    S_EMIT};
            S_EMIT:     w = '{UOP_EMIT,      COND_OUT_BUSY,  S_EMIT};
            S_IDLE:     w = '{UOP_ACCEPT,    COND_NO_IN,     S_IDLE};
            S_DISPATCH: w = '{UOP_DISPATCH,  COND_DISPATCH,  S_IDLE};
            default:    w = '{UOP_NOP,       COND_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ufc_table.sv =====
`timescale 1ns / 1ps

module ufc_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ufc_pkg::ufc_tbl_req_t req,
    output ufc_pkg::node_t       p_rd_data,
    output ufc_pkg::rank_t       k_rd_data
);
    import ufc_pkg::*;

    node_t                 pmem [MAX_NODES];
    rank_t                 kmem [MAX_NODES];
    logic [MAX_NODES-1:0]  pvalid_reg;
    logic [MAX_NODES-1:0]  kvalid_reg;

    node_t p_q_reg;
    node_t p_addr_reg;
    logic  p_v_reg;
    rank_t k_q_reg;
    logic  k_v_reg;

    // Entry valid bits: an entry never written since reset or reinit reads
    // as its reset value (own index for parent, zero for rank).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            kvalid_reg <= '0;
        end
        else if (req.clear)
        begin
            pvalid_reg <= '0;
            kvalid_reg <= '0;
        end
        else
        begin
            if (req.p_wr_en)
            begin
                pvalid_reg[req.p_wr_addr] <= 1'b1;
            end
            if (req.k_wr_en)
            begin
                kvalid_reg[req.k_wr_addr] <= 1'b1;
            end
        end
    end

    // Parent memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.p_wr_en)
        begin
            pmem[req.p_wr_addr] <= req.p_wr_data;
        end
        if (req.p_rd_en)
        begin
            p_q_reg    <= pmem[req.p_rd_addr];
            p_addr_reg <= req.p_rd_addr;
            p_v_reg    <= pvalid_reg[req.p_rd_addr];
        end
    end

    // Rank memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.k_wr_en)
        begin
            kmem[req.k_wr_addr] <= req.k_wr_data;
        end
        if (req.k_rd_en)
        begin
            k_q_reg <= kmem[req.k_rd_addr];
            k_v_reg <= kvalid_reg[req.k_rd_addr];
        end
    end

    assign p_rd_data = p_v_reg ? p_q_reg : p_addr_reg;
    assign k_rd_data = k_v_reg ? k_q_reg : '0;

endmodule

// ===== hw/rtl/ufc_datapath.sv =====
`timescale 1ns / 1ps

module ufc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ufc_pkg::ufc_ctrl_t ctrl,
    input  logic               in_fire,
    input  ufc_pkg::ufc_in_t   in_item,
    input  ufc_pkg::count_t    n,
    output ufc_pkg::ufc_stat_t stat,
    output ufc_pkg::ufc_out_t  result
);
    import ufc_pkg::*;

    ufc_mode_t mode_reg, mode_next;
    node_t     a_reg, a_next;
    node_t     b_reg, b_next;
    node_t     r_reg, r_next;
    node_t     cur_reg, cur_next;
    node_t     s1_reg, s1_next;
    node_t     s2_reg, s2_next;
    rank_t     rk1_reg, rk1_next;
    logic      phase_reg, phase_next;
    count_t    idx_reg, idx_next;
    count_t    cnt_reg, cnt_next;
    node_t     root_reg, root_next;
    logic      status_reg, status_next;

    ufc_tbl_req_t req;
    node_t        pdata;
    rank_t        kdata;
    logic         a_out, b_out, err;
    logic         link_lt;

    ufc_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .p_rd_data (pdata),
        .k_rd_data (kdata)
    );

    // Range check against the effective node count.
    assign a_out   = ({1'b0, a_reg} >= n);
    assign b_out   = ({1'b0, b_reg} >= n);
    assign err     = ((mode_reg == MODE_UNION) && (a_out || b_out)) ||
                     ((mode_reg == MODE_FIND) && a_out);
    assign link_lt = (rk1_reg < kdata);

    // Flags for the sequencer.
    always_comb
    begin
        stat.mode     = mode_reg;
        stat.err      = err;
        stat.par_ne_r = (pdata != r_reg);
        stat.cur_eq_r = (cur_reg == r_reg);
        stat.phase_b  = phase_reg;
        stat.roots_eq = (s1_reg == s2_reg);
        stat.idx_done = (idx_reg == n);
    end

    // Table accesses for the current step.
    always_comb
    begin
        req = '0;
        case (ctrl.uop)
            UOP_RD_R:
            begin
                req.p_rd_en   = 1'b1;
                req.p_rd_addr = r_reg;
            end
            UOP_RD_CUR:
            begin
                req.p_rd_en   = 1'b1;
                req.p_rd_addr = cur_reg;
            end
            UOP_COMPRESS:
            begin
                req.p_wr_en   = 1'b1;
                req.p_wr_addr = cur_reg;
                req.p_wr_data = r_reg;
            end
            UOP_RD_RANK1:
            begin
                req.k_rd_en   = 1'b1;
                req.k_rd_addr = s1_reg;
            end
            UOP_RD_RANK2:
            begin
                req.k_rd_en   = 1'b1;
                req.k_rd_addr = s2_reg;
            end
            UOP_LINK:
            begin
                // Lower rank goes under higher; on a tie the second root
                // goes under the first, whose rank rises unless saturated.
                req.p_wr_en = 1'b1;
                if (link_lt)
                begin
                    req.p_wr_addr = s1_reg;
                    req.p_wr_data = s2_reg;
                end
                else
                begin
                    req.p_wr_addr = s2_reg;
                    req.p_wr_data = s1_reg;
                    req.k_wr_en   = (rk1_reg == kdata) && (rk1_reg != RANK_MAX);
                    req.k_wr_addr = s1_reg;
                    req.k_wr_data = rk1_reg + 1'b1;
                end
            end
            UOP_CNT_RD:
            begin
                req.p_rd_en   = 1'b1;
                req.p_rd_addr = idx_reg[NODE_W-1:0];
            end
            UOP_REINIT:
            begin
                req.clear = 1'b1;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Register updates for the current step.
    always_comb
    begin
        mode_next   = mode_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        cur_next    = cur_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        rk1_next    = rk1_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        root_next   = root_reg;
        status_next = status_reg;
        case (ctrl.uop)
            UOP_ACCEPT:
            begin
                if (in_fire)
                begin
                    mode_next = ufc_mode_t'(in_item.mode);
                    a_next    = in_item.node_a;
                    b_next    = in_item.node_b;
                end
            end
            UOP_DISPATCH:
            begin
                status_next = err;
                r_next      = a_reg;
                cur_next    = a_reg;
                phase_next  = 1'b0;
                idx_next    = '0;
                cnt_next    = '0;
                root_next   = '0;
            end
            UOP_STEP_R:
            begin
                r_next = pdata;
            end
            UOP_COMPRESS:
            begin
                cur_next = pdata;
            end
            UOP_SAVE_ROOT:
            begin
                if (phase_reg)
                begin
                    s2_next = r_reg;
                end
                else
                begin
                    s1_next = r_reg;
                end
                root_next = r_reg;
            end
            UOP_LOAD_B:
            begin
                r_next     = b_reg;
                cur_next   = b_reg;
                phase_next = 1'b1;
            end
            UOP_RD_RANK2:
            begin
                rk1_next = kdata;
            end
            UOP_LINK:
            begin
                root_next = link_lt ? s2_reg : s1_reg;
            end
            UOP_CNT_STEP:
            begin
                // A node is a root when it is its own parent.
                if (pdata == idx_reg[NODE_W-1:0])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        cur_reg    <= cur_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        rk1_reg    <= rk1_next;
        phase_reg  <= phase_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end

    assign result.root            = root_reg;
    assign result.component_count = cnt_reg;
    assign result.status          = status_reg;

endmodule

// ===== hw/rtl/ufc_sequencer.sv =====
`timescale 1ns / 1ps

module ufc_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  ufc_pkg::ufc_stat_t stat,
    input  logic               in_fire,
    input  logic               out_busy,
    output ufc_pkg::ufc_ctrl_t ctrl
);
    import ufc_pkg::*;

    upc_t pc_reg, pc_next;
    upc_t dispatch_target;
    logic take;

    // Control word for the current step.
    assign ctrl = ufc_rom(pc_reg);

    // Entry point of each operation after the range check.
    always_comb
    begin
        if (stat.err)
        begin
            dispatch_target = S_EMIT;
        end
        else
        begin
            case (stat.mode)
                MODE_UNION:  dispatch_target = S_FIND_RD;
                MODE_FIND:   dispatch_target = S_FIND_RD;
                MODE_COUNT:  dispatch_target = S_CNT_RD;
                MODE_REINIT: dispatch_target = S_REINIT;
                default:     dispatch_target = S_REINIT;
            endcase
        end
    end

    // Jump condition.
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_IN:     take = !in_fire;
            COND_DISPATCH:  take = 1'b1;
            COND_PAR_NE_R:  take = stat.par_ne_r;
            COND_CUR_EQ_R:  take = stat.cur_eq_r;
            COND_MODE_FIND: take = (stat.mode == MODE_FIND);
            COND_PHASE_B:   take = stat.phase_b;
            COND_ROOTS_EQ:  take = stat.roots_eq;
            COND_IDX_DONE:  take = stat.idx_done;
            COND_OUT_BUSY:  take = out_busy;
            default:        take = 1'b0;
        endcase
    end

    // Next step address.
    always_comb
    begin
        if (ctrl.cond == COND_DISPATCH)
        begin
            pc_next = dispatch_target;
        end
        else if (take)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/union_find_components_core.sv =====
`timescale 1ns / 1ps

// Disjoint-set engine over 64 nodes with path compression and union by rank,
// run by a 16-step microprogram over one parent and one rank table, each with
// a single registered read port. One transaction is in work at a time; the
// result sits in an output register so the next transaction can be taken
// while it waits. A flagged item goes straight to the result register and a
// reinit clears the valid bits; a find walks from the node to its root, one
// parent read per hop, then walks the path again to repoint each node at the
// root; a union is the two finds and then, unless both nodes are already in
// one set, a rank read of each root and a link; a count reads the parent of
// each of the n nodes in use. Reset and reinit leave the tables valid at once
// through per-entry valid bits, so there is no clearing pass. vertex_count
// above 64 acts as 64 and may be written at any time the engine is idle; the
// write port is always ready.

module union_find_components_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ufc_pkg::ufc_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ufc_pkg::ufc_out_t  out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ufc_pkg::count_t    cfg_data
);
    import ufc_pkg::*;

    count_t    vc_reg;
    count_t    n_eff;
    ufc_ctrl_t ctrl;
    ufc_stat_t stat;
    ufc_out_t  result;
    ufc_out_t  out_data_reg;
    logic      out_valid_reg, out_valid_next;
    logic      in_fire;
    logic      out_busy;
    logic      emit;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vc_reg <= cfg_data;
        end
    end

    assign n_eff = (vc_reg > NODE_LIMIT) ? NODE_LIMIT : vc_reg;

    // Input transaction is taken only in the idle step.
    assign in_stall = (ctrl.uop != UOP_ACCEPT);
    assign in_fire  = in_valid && !in_stall;

    ufc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    ufc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_fire (in_fire),
        .in_item (in_data),
        .n       (n_eff),
        .stat    (stat),
        .result  (result)
    );

    // Output register: loaded by the emit step once the previous result
    // has been taken.
    assign out_busy = out_valid_reg && out_stall;
    assign emit     = (ctrl.uop == UOP_EMIT) && !out_busy;

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
